[sv/assert_macros.svh]
// Assertion macros shared by the particle table RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked every clock outside reset.
`define ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`endif

[sv/ptu_pkg.sv]
// Package for the particle table update block: sizes, codes and helpers.
`timescale 1ns / 1ps
package ptu_pkg;
   localparam int SLOTS = 4096;
   localparam int SLOT_W = $clog2(SLOTS);
   localparam int LANE_W = 21;
   localparam logic signed [LANE_W-1:0] LANE_MAX = 21'sd1048575;
   localparam logic signed [LANE_W-1:0] LANE_MIN = -21'sd1048576;
   localparam logic signed [LANE_W-1:0] GROUND_RESET = 21'sd819;
   localparam logic signed [LANE_W-1:0] AIR_RESET = 21'sd983;
   localparam logic [0:0] CSR_GROUND = 1'b0;
   localparam logic [0:0] CSR_AIR = 1'b1;
   localparam logic KIND_SPAWN = 1'b0;

   // Saturate a wide signed value to one lane.
   function automatic logic signed [LANE_W-1:0] sat_lane(input logic signed [47:0] v);
      logic signed [LANE_W-1:0] r;
      if (v > 48'(LANE_MAX)) r = LANE_MAX;
      else if (v < 48'(LANE_MIN)) r = LANE_MIN;
      else r = v[LANE_W-1:0];
      return r;
   endfunction
endpackage

[sv/ptu_divider.sv]
// Restoring serial divider for the 9-bit age ratio, one quotient bit a cycle.
`timescale 1ns / 1ps
module ptu_divider (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [23:0] age,
   input  logic [23:0] span,
   output logic        done,
   output logic [8:0]  ratio
);
   logic [3:0]  count_ff, count_in;
   logic        busy_ff, busy_in;
   logic [24:0] rem_ff, rem_in;
   logic [8:0]  quot_ff, quot_in;
   logic        over_ff, over_in;
   logic [24:0] trial;

   // Age >= span means ratio 256; otherwise eight quotient bits of age/span.
   assign trial = {rem_ff[23:0], 1'b0} - {1'b0, span};
   always_comb begin
      count_in = count_ff;
      busy_in = busy_ff;
      rem_in = rem_ff;
      quot_in = quot_ff;
      over_in = over_ff;
      done = 1'b0;
      if (start) begin
         busy_in = 1'b1;
         count_in = 4'd0;
         rem_in = {1'b0, age};
         quot_in = '0;
         over_in = (age >= span);
      end else if (busy_ff) begin
         if (over_ff || count_ff == 4'd8) begin
            busy_in = 1'b0;
            done = 1'b1;
         end else begin
            count_in = count_ff + 4'd1;
            if (!trial[24]) begin
               rem_in = trial;
               quot_in = {quot_ff[7:0], 1'b1};
            end else begin
               rem_in = {rem_ff[23:0], 1'b0};
               quot_in = {quot_ff[7:0], 1'b0};
            end
         end
      end
   end
   assign ratio = over_ff ? 9'd256 : quot_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         count_ff <= count_in;
      end
      rem_ff <= rem_in;
      quot_ff <= quot_in;
      over_ff <= over_in;
   end
endmodule

[sv/particle_table_update.sv]
// Top level of the particle table update block.
`timescale 1ns / 1ps
`include "assert_macros.svh"
// Particle table update.
// Requests arrive on req_* (valid/stall). One result per request leaves on
// rsp_* (valid/stall). A spawn request writes the particle into the next ring
// slot. An update request advances the named live slot by one frame.
// A spawn loads the output register straight from the request. An update of a
// dead slot gives an empty result after the table read. A live update runs the
// table read and age states, gravity, the force add, the decay factor, the
// shared multiplier for each force lane in turn, the divider for the age ratio
// (skipped when the span is zero), four colour channels and the write back.
// The block takes one request at a time. req_stall stays high until the result
// sits in the output register and has been taken. A result that waits under
// rsp_stall holds, and no new request is taken meanwhile.
// The ground and airborne levels are set through the csr_* write port.
// After reset a clearing pass over all 4096 slots zeroes the live flags. req_stall
// stays high during it. Reset also clears the spawn pointer and sets the levels
// to their defaults. The other tables are not cleared.
module particle_table_update (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_kind,
   input  logic [11:0] req_slot,
   input  logic [15:0] req_frame_time,
   input  logic [62:0] req_start_position,
   input  logic [62:0] req_start_force,
   input  logic signed [23:0] req_gravity_step,
   input  logic [23:0] req_life_span,
   input  logic [11:0] req_decay_rate,
   input  logic [31:0] req_first_color,
   input  logic [31:0] req_last_color,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [11:0] rsp_slot_out,
   output logic        rsp_alive_out,
   output logic [62:0] rsp_position_out,
   output logic [31:0] rsp_color_out,
   output logic [8:0]  rsp_age_ratio,
   input  logic        csr_write,
   input  logic [0:0]  csr_index,
   input  logic [20:0] csr_data
);
   localparam int SW = ptu_pkg::SLOT_W;
   localparam logic [3:0] ST_IDLE = 4'd0, ST_READ = 4'd1, ST_AGE = 4'd2,
      ST_GRAV = 4'd3, ST_ADD = 4'd4, ST_FACT = 4'd5, ST_MUL = 4'd6,
      ST_MULW = 4'd7, ST_DIV = 4'd8, ST_LERP = 4'd9, ST_WRITE = 4'd10,
      ST_OUT = 4'd11, ST_CLEAR = 4'd12, ST_DEAD = 4'd13;

   // Tables.
   logic [62:0] pos_mem [ptu_pkg::SLOTS];
   logic [62:0] frc_mem [ptu_pkg::SLOTS];
   logic [23:0] grav_mem [ptu_pkg::SLOTS];
   logic [31:0] fall_mem [ptu_pkg::SLOTS];
   logic [23:0] age_mem [ptu_pkg::SLOTS];
   logic [23:0] span_mem [ptu_pkg::SLOTS];
   logic [11:0] decay_mem [ptu_pkg::SLOTS];
   logic [63:0] color_mem [ptu_pkg::SLOTS];
   logic        live_mem [ptu_pkg::SLOTS];

   logic [3:0]  state_ff;
   logic [SW-1:0] ptr_ff;
   logic [SW-1:0] clr_ff;
   logic signed [20:0] ground_ff, air_ff;
   // Request copy.
   logic [11:0] slot_ff;
   logic [15:0] ft_ff;
   // Working entry.
   logic signed [20:0] pos_ff [3];
   logic signed [20:0] frc_ff [3];
   logic [62:0] rpos, rfrc;
   logic signed [23:0] grav_ff, rgrav;
   logic signed [31:0] fall_ff, rfall;
   logic [23:0] age_ff, rage, span_ff, rspan;
   logic [11:0] rdecay;
   logic [63:0] rcolor;
   logic        rlive;
   logic signed [29:0] factor_ff;
   logic [1:0]  lane_ff;
   logic [2:0]  chan_ff;
   logic signed [53:0] prod_ff;
   logic [8:0]  ratio_ff;
   logic [31:0] color_ff;
   // Result register.
   logic        ovalid_ff;
   logic [11:0] oslot_ff;
   logic        oalive_ff;
   logic [62:0] opos_ff;
   logic [31:0] ocolor_ff;
   logic [8:0]  oratio_ff;

   logic        div_start, div_done;
   logic [8:0]  div_ratio;
   logic        accept;
   logic        spawn_go;
   logic [SW-1:0] idx;
   logic signed [29:0] mul_a;
   logic signed [23:0] mul_b;
   logic signed [53:0] mul_p;
   logic [24:0] age_sum;
   logic signed [32:0] fall_sum;
   logic signed [23:0] drop;
   logic [7:0]  cs, ce;
   logic [16:0] lerp_sum;

   assign req_stall = (state_ff != ST_IDLE) || (ovalid_ff && rsp_stall);
   assign accept = req_valid && !req_stall;
   assign spawn_go = accept && (req_kind == ptu_pkg::KIND_SPAWN);
   assign idx = slot_ff[SW-1:0];

   // Shared multiplier: frame time times decay rate, or decay factor times force lane.
   always_comb begin
      mul_a = factor_ff;
      mul_b = 24'(frc_ff[lane_ff]);
      if (state_ff == ST_FACT) begin
         mul_a = 30'(ft_ff);
         mul_b = 24'(rdecay);
      end
   end
   assign mul_p = 54'(mul_a) * 54'(mul_b);

   ptu_divider u_div (
      .clock(clock), .reset(reset), .start(div_start), .age(age_ff),
      .span(span_ff), .done(div_done), .ratio(div_ratio)
   );
   assign div_start = (state_ff == ST_MULW) && (lane_ff == 2'd2) && (span_ff != '0);

   assign age_sum = {1'b0, rage} + 25'(ft_ff);
   assign fall_sum = 33'(fall_ff) + 33'(grav_ff);
   assign drop = 24'((34'(fall_ff) + 34'sd256) >>> 9);
   assign cs = rcolor[8*chan_ff[1:0] +: 8];
   assign ce = rcolor[32 + 8*chan_ff[1:0] +: 8];
   assign lerp_sum = 17'(cs) * 17'(9'd256 - ratio_ff) + 17'(ce) * 17'(ratio_ff);

   // Table writes and registered reads.
   always_ff @(posedge clock) begin
      rpos <= pos_mem[idx];
      rfrc <= frc_mem[idx];
      rgrav <= grav_mem[idx];
      rfall <= fall_mem[idx];
      rage <= age_mem[idx];
      rspan <= span_mem[idx];
      rdecay <= decay_mem[idx];
      rcolor <= color_mem[idx];
      rlive <= live_mem[idx];
      if (spawn_go) begin
         pos_mem[ptr_ff] <= req_start_position;
         frc_mem[ptr_ff] <= req_start_force;
         grav_mem[ptr_ff] <= req_gravity_step;
         fall_mem[ptr_ff] <= '0;
         age_mem[ptr_ff] <= '0;
         span_mem[ptr_ff] <= req_life_span;
         decay_mem[ptr_ff] <= req_decay_rate;
         color_mem[ptr_ff] <= {req_last_color, req_first_color};
      end else if (state_ff == ST_WRITE) begin
         pos_mem[idx] <= {pos_ff[2], pos_ff[1], pos_ff[0]};
         frc_mem[idx] <= {frc_ff[2], frc_ff[1], frc_ff[0]};
         grav_mem[idx] <= grav_ff;
         fall_mem[idx] <= fall_ff;
         age_mem[idx] <= age_ff;
      end
      // Live flags: clearing pass, spawn, death.
      if (state_ff == ST_CLEAR) live_mem[clr_ff] <= 1'b0;
      else if (spawn_go) live_mem[ptr_ff] <= 1'b1;
      else if (state_ff == ST_WRITE && ratio_ff == 9'd256) live_mem[idx] <= 1'b0;
   end

   // Sequencer.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         clr_ff <= '0;
         ptr_ff <= '0;
         ground_ff <= ptu_pkg::GROUND_RESET;
         air_ff <= ptu_pkg::AIR_RESET;
         ovalid_ff <= 1'b0;
      end else begin
         if (csr_write) begin
            if (csr_index == ptu_pkg::CSR_GROUND) ground_ff <= csr_data;
            else air_ff <= csr_data;
         end
         if (state_ff == ST_OUT) ovalid_ff <= 1'b1;
         else if (ovalid_ff && !rsp_stall) ovalid_ff <= 1'b0;
         case (state_ff)
            ST_CLEAR: begin
               clr_ff <= clr_ff + 1'b1;
               if (clr_ff == SW'(ptu_pkg::SLOTS - 1)) state_ff <= ST_IDLE;
            end
            ST_IDLE: begin
               if (accept) begin
                  slot_ff <= req_slot;
                  ft_ff <= req_frame_time;
                  if (req_kind == ptu_pkg::KIND_SPAWN) begin
                     ptr_ff <= ptr_ff + 1'b1;
                     oslot_ff <= 12'(ptr_ff);
                     oalive_ff <= 1'b1;
                     opos_ff <= req_start_position;
                     ocolor_ff <= req_first_color;
                     oratio_ff <= '0;
                     state_ff <= ST_OUT;
                  end else begin
                     state_ff <= ST_READ;
                  end
               end
            end
            ST_DEAD: begin
               oslot_ff <= slot_ff;
               oalive_ff <= 1'b0;
               opos_ff <= '0;
               ocolor_ff <= '0;
               oratio_ff <= '0;
               state_ff <= ST_OUT;
            end
            ST_READ: state_ff <= ST_AGE;
            ST_AGE: begin
               pos_ff[0] <= rpos[20:0];
               pos_ff[2] <= rpos[62:42];
               if ($signed(rpos[41:21]) <= ground_ff) pos_ff[1] <= ground_ff;
               else pos_ff[1] <= rpos[41:21];
               for (int k = 0; k < 3; k++)
                  frc_ff[k] <= rfrc[21*k +: 21];
               age_ff <= age_sum[24] ? 24'hFFFFFF : age_sum[23:0];
               span_ff <= rspan;
               grav_ff <= rgrav;
               fall_ff <= rfall;
               if (32'(slot_ff) >= ptu_pkg::SLOTS || !rlive) state_ff <= ST_DEAD;
               else state_ff <= ST_GRAV;
            end
            ST_GRAV: begin
               if (pos_ff[1] > air_ff) begin
                  pos_ff[1] <= ptu_pkg::sat_lane(48'(pos_ff[1]) - 48'(drop));
                  if (fall_sum > 33'sh07FFFFFFF) fall_ff <= 32'sh7FFFFFFF;
                  else if (fall_sum < -33'sh080000000) fall_ff <= 32'sh80000000;
                  else fall_ff <= fall_sum[31:0];
               end else begin
                  frc_ff[1] <= '0;
                  grav_ff <= '0;
               end
               lane_ff <= '0;
               state_ff <= ST_ADD;
            end
            ST_ADD: begin
               for (int k = 0; k < 3; k++)
                  pos_ff[k] <= ptu_pkg::sat_lane(48'(pos_ff[k]) + 48'(frc_ff[k]));
               state_ff <= ST_FACT;
            end
            ST_FACT: begin
               factor_ff <= 30'sh1000000 - 30'(mul_p);
               state_ff <= ST_MUL;
            end
            ST_MUL: begin
               prod_ff <= mul_p;
               state_ff <= ST_MULW;
            end
            ST_MULW: begin
               frc_ff[lane_ff] <= ptu_pkg::sat_lane(48'((prod_ff + 54'sh800000) >>> 24));
               if (lane_ff == 2'd2) begin
                  chan_ff <= '0;
                  ratio_ff <= '0;
                  state_ff <= ST_DIV;
               end else begin
                  lane_ff <= lane_ff + 2'd1;
                  state_ff <= ST_MUL;
               end
            end
            ST_DIV: begin
               if (span_ff == '0) state_ff <= ST_LERP;
               else if (div_done) begin
                  ratio_ff <= div_ratio;
                  state_ff <= ST_LERP;
               end
            end
            ST_LERP: begin
               color_ff[8*chan_ff[1:0] +: 8] <= lerp_sum[15:8];
               if (chan_ff == 3'd3) state_ff <= ST_WRITE;
               chan_ff <= chan_ff + 3'd1;
            end
            ST_WRITE: begin
               oslot_ff <= slot_ff;
               oalive_ff <= (ratio_ff != 9'd256);
               opos_ff <= {pos_ff[2], pos_ff[1], pos_ff[0]};
               ocolor_ff <= color_ff;
               oratio_ff <= ratio_ff;
               state_ff <= ST_OUT;
            end
            ST_OUT: state_ff <= ST_IDLE;
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp_valid = ovalid_ff;
   assign rsp_slot_out = oslot_ff;
   assign rsp_alive_out = oalive_ff;
   assign rsp_position_out = opos_ff;
   assign rsp_color_out = ocolor_ff;
   assign rsp_age_ratio = oratio_ff;

   `ASSERT_IMP(a_busy_stalls, clock, reset, state_ff != ST_IDLE, req_stall)
   `ASSERT_NXT(a_spawn_adv, clock, reset, spawn_go, ptr_ff == $past(ptr_ff) + 1'b1)
   `ASSERT_IMP(a_ratio_range, clock, reset, rsp_valid, rsp_age_ratio <= 9'd256)
endmodule
